// ===== sv/price_level_fifo_match_core_assert.svh =====
// Assertion macros shared by the checker of the price level core.
// No dependencies; included by files that assert.
`ifndef PRICE_LEVEL_FIFO_MATCH_CORE_ASSERT_SVH
`define PRICE_LEVEL_FIFO_MATCH_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PLF_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PLF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/plfm_pkg.sv =====
// Package for the price level core: payload structs, codes, constants.
// No dependencies.
package plfm_pkg;
  localparam int QueueDepth = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FILL   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FILLED = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] req_id;
    logic [31:0] order_qty;
    logic [31:0] order_price;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] matched_id;
    logic [31:0] remaining_qty;
    logic        ok;
    logic        last;
  } out_word_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [1:0]  operation;
    logic        price_ok;
    logic [31:0] req_id;
    logic [31:0] order_qty;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_DONE
  } state_t;
endpackage

// ===== sv/plfm_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module plfm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/plfm_front.sv =====
// Front part: accepts input words, compares price, drops unused codes, and
// holds a two-entry command queue. Depends on plfm_pkg.
module plfm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  plfm_pkg::in_word_t in_word,
  input  logic [31:0]       level_price,
  output logic              cmd_valid,
  output plfm_pkg::cmd_t    cmd,
  input  logic              cmd_take
);
  import plfm_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       wr_en;
  cmd_t       cmd_in;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_comb begin
    cmd_in.operation = in_word.operation;
    cmd_in.price_ok  = (in_word.order_price == level_price);
    cmd_in.req_id    = in_word.req_id;
    cmd_in.order_qty = in_word.order_qty;
  end

  // Drop unused operation codes here.
  assign wr_en = push && !full && (in_word.operation != OP_NONE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, wr_en} - {1'b0, cmd_take};
    end
  end
endmodule

// ===== sv/plfm_back.sv =====
// Back part: executes add, fill and cancel over the resting queue in RAM,
// compacting in place, and drives a two-entry result queue.
// Depends on plfm_pkg and plfm_ram.
module plfm_back #(
  parameter int QueueDepth = plfm_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  plfm_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output logic               empty,
  input  logic               pop,
  output plfm_pkg::out_word_t out_word
);
  import plfm_pkg::*;

  localparam int AW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  state_t      state, state_next;
  cmd_t        cur;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;   // next entry to be read by the walk
  logic [CW-1:0] wr_idx;   // compaction write position
  logic [31:0] rem;
  logic        found;
  logic [31:0] rid, rqty;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] wid, wqty;

  // Result queue, two entries.
  out_word_t   rq [2];
  logic        rq_rd, rq_wr;
  logic [1:0]  rq_fill;
  logic        res_we;
  out_word_t   res;

  plfm_ram #(.Width(32), .Depth(QueueDepth)) u_ids (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(wid),
    .raddr(ram_raddr), .rdata(rid));
  plfm_ram #(.Width(32), .Depth(QueueDepth)) u_qtys (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(wqty),
    .raddr(ram_raddr), .rdata(rqty));

  assign empty    = (rq_fill == 2'd0);
  assign out_word = rq[rq_rd];

  logic rq_room;
  assign rq_room = (rq_fill != 2'd2) || pop;

  // Walk-step values for the entry whose data is now on rid/rqty.
  logic [31:0] take, new_qty;
  logic        step_drop;
  always_comb begin
    take      = (rem < rqty) ? rem : rqty;
    new_qty   = rqty - take;
    step_drop = 1'b0;
    if (cur.operation == OP_FILL) begin
      step_drop = (rem != 32'd0) && (new_qty == 32'd0);
    end else if (cur.operation == OP_CANCEL) begin
      step_drop = !found && (rid == cur.req_id);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.operation == OP_ADD) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_next = (count == '0) ? ST_DONE : ST_WALK;
      ST_WALK: begin
        if (rq_room && rd_idx == count) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rq_room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_take  = (state == ST_IDLE) && cmd_valid;
    ram_we    = 1'b0;
    ram_waddr = wr_idx[AW-1:0];
    wid       = rid;
    wqty      = rqty;
    ram_raddr = rd_idx[AW-1:0];
    res_we    = 1'b0;
    res       = '0;
    case (state)
      ST_IDLE: ram_raddr = '0;
      ST_READ: ram_raddr = '0;
      ST_WALK: begin
        if (rq_room) begin
          if (cur.operation == OP_FILL) begin
            wqty = new_qty;
          end
          ram_we = !step_drop;
          if (step_drop && cur.operation == OP_FILL) begin
            res_we         = 1'b1;
            res.kind       = KIND_FILLED;
            res.matched_id = rid;
            res.ok         = 1'b1;
          end
          ram_raddr = (rd_idx == count) ? '0 : rd_idx[AW-1:0];
        end else begin
          // Hold: read the entry now on rid again.
          ram_raddr = rd_idx[AW-1:0] - 1'b1;
        end
      end
      ST_DONE: begin
        res.last = 1'b1;
        res_we   = rq_room;
        if (cur.operation == OP_ADD) begin
          res.kind  = KIND_ADD;
          res.ok    = cur.price_ok && (count != CW'(QueueDepth));
          ram_we    = rq_room && res.ok;
          ram_waddr = count[AW-1:0];
          wid       = cur.req_id;
          wqty      = cur.order_qty;
        end else if (cur.operation == OP_FILL) begin
          res.kind          = KIND_DONE;
          res.remaining_qty = rem;
          res.ok            = 1'b1;
        end else begin
          res.kind = KIND_CANCEL;
          res.ok   = found;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      rq[rq_wr] <= res;
    end
    if (state == ST_IDLE && cmd_valid) begin
      cur <= cmd;
      rem <= cmd.order_qty;
    end
    if (state == ST_WALK && rq_room && cur.operation == OP_FILL) begin
      rem <= rem - take;
    end
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_idx  <= '0;
      wr_idx  <= '0;
      found   <= 1'b0;
      rq_rd   <= 1'b0;
      rq_wr   <= 1'b0;
      rq_fill <= 2'd0;
    end else begin
      state <= state_next;
      if (res_we) begin
        rq_wr <= ~rq_wr;
      end
      if (pop && !empty) begin
        rq_rd <= ~rq_rd;
      end
      rq_fill <= rq_fill + {1'b0, res_we} - {1'b0, pop && !empty};
      case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          wr_idx <= '0;
          found  <= 1'b0;
        end
        ST_READ: rd_idx <= CW'(1);
        ST_WALK: begin
          if (rq_room) begin
            if (!step_drop) begin
              wr_idx <= wr_idx + 1'b1;
            end else if (cur.operation == OP_CANCEL) begin
              found <= 1'b1;
            end
            if (rd_idx != count) begin
              rd_idx <= rd_idx + 1'b1;
            end else begin
              count <= step_drop ? wr_idx : wr_idx + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (rq_room && cur.operation == OP_ADD && res.ok) begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/price_level_fifo_match_core.sv =====
// Top level of the price level core: front command queue and back executor.
// Depends on plfm_pkg, plfm_front, plfm_back.
//
// One price level of an order book holding a FIFO of up to QueueDepth resting
// orders in two RAMs. Once the back part is free, an add goes from IDLE to
// DONE, where its result is written; a fill or cancel passes through READ,
// one WALK step per resting order and DONE. The walk reads one entry per
// cycle while the output queue has room and writes back each kept entry. Up to two
// commands wait in the front queue while the back part works, and results
// wait in a two-word output queue; a full output queue stalls the walk.
module price_level_fifo_match_core #(
  parameter int QueueDepth = plfm_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  plfm_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output plfm_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data
);
  import plfm_pkg::*;

  logic [31:0] level_price;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_price <= '0;
    end else if (cfg_we) begin
      level_price <= cfg_data;
    end
  end

  plfm_front u_front (
    .clk, .rst, .push, .full, .in_word, .level_price,
    .cmd_valid, .cmd, .cmd_take);

  plfm_back #(.QueueDepth(QueueDepth)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .out_word);
endmodule

// ===== sv/plfm_checker.sv =====
// Port-level checker for the price level core, with its bind.
// Depends on plfm_pkg and price_level_fifo_match_core_assert.svh.
`include "price_level_fifo_match_core_assert.svh"
module plfm_checker (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input plfm_pkg::out_word_t out_word
);
  import plfm_pkg::*;

  `PLF_ASSERT_IMPL(a_done_last, clk, rst, !empty && out_word.kind == KIND_DONE, out_word.last)
  `PLF_ASSERT_IMPL(a_filled_not_last, clk, rst, !empty && out_word.kind == KIND_FILLED, !out_word.last && out_word.ok)
  `PLF_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(out_word))
endmodule

bind price_level_fifo_match_core plfm_checker u_chk (
  .clk, .rst, .empty, .pop, .out_word);
